// ===== hw/rtl/mf3_pkg.sv =====
`default_nettype none

package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int IN_ROW_W   = 13;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int MIN_DIM    = 3;
  localparam int WIDTH_RST  = 416;
  localparam int HEIGHT_RST = 240;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // one line buffer word: the row above and the current row at one column
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_pair_t;

  // one window column, sorted, plus the raw value of its middle row
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
    pix_t ctr;
  } col_t;

  // vld: the item yields a result; border: pass the center through
  typedef struct packed {
    logic vld;
    logic border;
    logic last;
  } pix_ctl_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort_col(input pix_t top, input pix_t mid, input pix_t bot);
    col_t c;
    c.lo  = min3(top, mid, bot);
    c.md  = med3(top, mid, bot);
    c.hi  = max3(top, mid, bot);
    c.ctr = mid;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mf3_line_buf.sv =====
`default_nettype none

module mf3_line_buf #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output mf3_pkg::line_pair_t           rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire mf3_pkg::line_pair_t      wr_data
);

  mf3_pkg::line_pair_t mem [DEPTH];
  mf3_pkg::line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mf3_col_cell.sv =====
`default_nettype none

module mf3_col_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire mf3_pkg::col_t col_i,
  output mf3_pkg::col_t      col_o
);

  mf3_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_i;
    end
  end

  assign col_o = col_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mf3_median.sv =====
`default_nettype none

// Median of nine from three sorted columns:
// med3(max of lows, med of mids, min of highs); border items pass the center through.
module mf3_median (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire mf3_pkg::pix_ctl_t ctl_i,
  input  wire mf3_pkg::col_t     col_new_i,
  input  wire mf3_pkg::col_t     col_mid_i,
  input  wire mf3_pkg::col_t     col_old_i,
  output mf3_pkg::pix_ctl_t      ctl_o,
  output mf3_pkg::pix_t          px_o
);

  mf3_pkg::pix_ctl_t a_ctl_r;
  mf3_pkg::pix_t     a_lo_r;
  mf3_pkg::pix_t     a_md_r;
  mf3_pkg::pix_t     a_hi_r;
  mf3_pkg::pix_t     a_ctr_r;
  mf3_pkg::pix_ctl_t b_ctl_r;
  mf3_pkg::pix_t     b_px_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
      b_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= ctl_i;
      b_ctl_r <= a_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo_r  <= mf3_pkg::max3(col_new_i.lo, col_mid_i.lo, col_old_i.lo);
      a_md_r  <= mf3_pkg::med3(col_new_i.md, col_mid_i.md, col_old_i.md);
      a_hi_r  <= mf3_pkg::min3(col_new_i.hi, col_mid_i.hi, col_old_i.hi);
      a_ctr_r <= col_mid_i.ctr;
      b_px_r  <= a_ctl_r.border ? a_ctr_r : mf3_pkg::med3(a_lo_r, a_md_r, a_hi_r);
    end
  end

  assign ctl_o = b_ctl_r;
  assign px_o  = b_px_r;

endmodule

`default_nettype wire

// ===== hw/rtl/median_filter_3x3.sv =====
`default_nettype none

// 3x3 median filter for 8-bit greyscale frames.
// Input stream: in_tdata carries a pixel, in_tuser marks a flush item (pixel
// ignored, taken as zero). Send one frame in raster order, then
// image_width+1 flush items. From stream position image_width+1 on, every
// input transfer yields one output transfer, in raster order; border pixels
// pass through, interior pixels get the median of their 3x3 neighborhood.
// out_tlast marks the last pixel of the frame; the counters then restart.
// Throughput is one pixel per cycle unless the output stalls: a
// single-port-read line buffer memory and a chain of three column cells
// feed a two-stage median tree and then the output register.
// A stalled output parks one result in a skid register; in_tready falls
// only while that register is full, so the whole pipeline holds.
// Reset clears counters, window and valid flags; the line buffers are not
// cleared. Write cfg registers (0: image_width, 1: image_height) only while
// the block is idle; values are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] pixel
  input  wire logic                           in_tuser,   // [0] flush
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [7:0]                     out_tdata,  // [7:0] filtered_pixel
  output      logic                           out_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [mf3_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [mf3_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int W_RST  = (mf3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : mf3_pkg::WIDTH_RST;
  localparam int H_RST  = (mf3_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : mf3_pkg::HEIGHT_RST;
  localparam int NCELLS = 3;

  // ---------------- configuration ----------------
  logic [CW-1:0] w_m1_r, w_m1_nxt;
  logic [RW-1:0] h_m1_r, h_m1_nxt;
  logic [31:0]   w_raw, w_cl, h_raw, h_cl;

  always_comb begin
    w_raw = 32'(cfg_wdata[mf3_pkg::WIDTH_W-1:0]);
    h_raw = 32'(cfg_wdata[mf3_pkg::HEIGHT_W-1:0]);
    if (w_raw < 32'(mf3_pkg::MIN_DIM)) begin
      w_cl = 32'(mf3_pkg::MIN_DIM);
    end else if (w_raw > 32'(MAX_WIDTH)) begin
      w_cl = 32'(MAX_WIDTH);
    end else begin
      w_cl = w_raw;
    end
    if (h_raw < 32'(mf3_pkg::MIN_DIM)) begin
      h_cl = 32'(mf3_pkg::MIN_DIM);
    end else if (h_raw > 32'(MAX_HEIGHT)) begin
      h_cl = 32'(MAX_HEIGHT);
    end else begin
      h_cl = h_raw;
    end
    w_m1_nxt = CW'(w_cl - 32'd1);
    h_m1_nxt = RW'(h_cl - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= CW'(W_RST - 1);
      h_m1_r <= RW'(H_RST - 1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mf3_pkg::REG_IMAGE_WIDTH:  w_m1_r <= w_m1_nxt;
        mf3_pkg::REG_IMAGE_HEIGHT: h_m1_r <= h_m1_nxt;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic skid_vld_r;
  logic adv;
  logic accept;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  // ---------------- position counters ----------------
  logic [CW-1:0]                  in_col_r, in_col_nxt;
  logic [mf3_pkg::IN_ROW_W-1:0]   in_row_r, in_row_nxt;
  logic [CW-1:0]                  out_col_r, out_col_nxt;
  logic [RW-1:0]                  out_row_r, out_row_nxt;
  logic                           emit, in_wrap, oc_wrap, or_end, border, last;

  always_comb begin
    emit    = (in_row_r >= mf3_pkg::IN_ROW_W'(2)) ||
              ((in_row_r == mf3_pkg::IN_ROW_W'(1)) && (in_col_r != '0));
    in_wrap = in_col_r >= w_m1_r;
    oc_wrap = out_col_r >= w_m1_r;
    or_end  = out_row_r >= h_m1_r;
    border  = (out_row_r == '0) || or_end || (out_col_r == '0) || oc_wrap;
    last    = oc_wrap && or_end;

    in_col_nxt  = in_wrap ? '0 : in_col_r + CW'(1);
    in_row_nxt  = in_wrap ? in_row_r + mf3_pkg::IN_ROW_W'(1) : in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      if (oc_wrap) begin
        out_col_nxt = '0;
        if (or_end) begin
          // end of frame: restart all counters
          out_row_nxt = '0;
          in_row_nxt  = '0;
          in_col_nxt  = '0;
        end else begin
          out_row_nxt = out_row_r + RW'(1);
        end
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (accept) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------- stage 1: line buffer access ----------------
  logic                s1_vld_r;
  mf3_pkg::pix_ctl_t   s1_ctl_r;
  mf3_pkg::pix_t       s1_px_r;
  logic [CW-1:0]       s1_col_r;
  logic                fwd_r;
  mf3_pkg::line_pair_t fwd_data_r;
  mf3_pkg::line_pair_t lb_rd, rd_eff, lb_wr;
  logic                lb_we;

  // the write of the item in stage 1 lands at the same edge as the next read
  assign rd_eff       = fwd_r ? fwd_data_r : lb_rd;
  assign lb_wr.upper  = rd_eff.middle;
  assign lb_wr.middle = s1_px_r;
  assign lb_we        = adv && s1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= accept;
      fwd_r    <= accept && s1_vld_r && (s1_col_r == in_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r.vld    <= emit;
      s1_ctl_r.border <= border;
      s1_ctl_r.last   <= last;
      s1_px_r         <= in_tuser ? '0 : in_tdata[mf3_pkg::PIX_W-1:0];
      s1_col_r        <= in_col_r;
      fwd_data_r      <= lb_wr;
    end
  end

  mf3_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk    (clk),
    .rd_en  (adv),
    .rd_addr(in_col_r),
    .rd_data(lb_rd),
    .wr_en  (lb_we),
    .wr_addr(s1_col_r),
    .wr_data(lb_wr)
  );

  // ---------------- stage 2: window column chain ----------------
  mf3_pkg::col_t     col_chain [NCELLS+1];
  mf3_pkg::pix_ctl_t s2_ctl_r;

  assign col_chain[0] = mf3_pkg::sort_col(rd_eff.upper, rd_eff.middle, s1_px_r);

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    mf3_col_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_en(lb_we),
      .col_i   (col_chain[k]),
      .col_o   (col_chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r.vld    <= s1_vld_r && s1_ctl_r.vld;
      s2_ctl_r.border <= s1_ctl_r.border;
      s2_ctl_r.last   <= s1_ctl_r.last;
    end
  end

  // ---------------- stages 3 and 4: median ----------------
  mf3_pkg::pix_ctl_t fin_ctl;
  mf3_pkg::pix_t     fin_px;

  mf3_median u_median (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .ctl_i    (s2_ctl_r),
    .col_new_i(col_chain[1]),
    .col_mid_i(col_chain[2]),
    .col_old_i(col_chain[3]),
    .ctl_o    (fin_ctl),
    .px_o     (fin_px)
  );

  // ---------------- output register and skid ----------------
  logic          out_vld_r;
  mf3_pkg::pix_t out_px_r;
  logic          out_last_r;
  mf3_pkg::pix_t skid_px_r;
  logic          skid_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= fin_ctl.vld;
    end else if (fin_ctl.vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_px_r   <= skid_px_r;
        out_last_r <= skid_last_r;
      end
    end else if (!out_vld_r || out_tready) begin
      out_px_r   <= fin_px;
      out_last_r <= fin_ctl.last;
    end else begin
      // park the result while the receiver stalls
      skid_px_r   <= fin_px;
      skid_last_r <= fin_ctl.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_px_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid filled without an output stall");

  a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_vld_r)
    else $error("line buffer bypass active without an item in stage 1");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 4096;
  localparam int SETTLE       = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 600;
  localparam int CALM_ITEMS   = 300;

  typedef enum int {PAT_NOISE, PAT_NARROW, PAT_BINARY, PAT_SPECKLE} pattern_e;

  typedef struct packed {
    mf3_pkg::pix_t pix;
    logic          last;
  } filtered_pix_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // [7:0] pixel
  logic                           in_tuser;   // [0] flush
  logic                           out_tvalid;
  logic                           out_tready;
  logic [7:0]                     out_tdata;  // [7:0] filtered_pixel
  logic                           out_tlast;
  logic                           cfg_we;
  logic [mf3_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_wdata;

  median_filter_3x3 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // filter state as the block should hold it
  mf3_pkg::pix_t row_above   [0:MAX_W-1];
  mf3_pkg::pix_t row_current [0:MAX_W-1];
  mf3_pkg::pix_t nbhd        [0:8];
  int unsigned   wr_col, wr_row, rd_col, rd_row;
  logic [10:0]   frame_w_reg;
  logic [12:0]   frame_h_reg;

  filtered_pix_t expected_pixels [$];
  filtered_pix_t want;

  int unsigned err_count;
  int unsigned items_sent;
  int unsigned pixels_checked;
  int unsigned frames_seen;
  int unsigned quiet_cycles;
  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  int unsigned hold_left;
  bit          hold_toggle;
  bit          hold_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void report_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < mf3_pkg::MIN_DIM) return mf3_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic mf3_pkg::pix_t rank_middle();
    mf3_pkg::pix_t s [0:8];
    mf3_pkg::pix_t t;
    for (int i = 0; i < 9; i++) s[i] = nbhd[i];
    for (int i = 0; i < 5; i++) begin
      for (int j = i + 1; j < 9; j++) begin
        if (s[j] < s[i]) begin
          t = s[i];
          s[i] = s[j];
          s[j] = t;
        end
      end
    end
    return s[4];
  endfunction

  function automatic void filter_reset();
    for (int i = 0; i < MAX_W; i++) begin
      row_above[i] = '0;
      row_current[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    wr_col = 0;
    wr_row = 0;
    rd_col = 0;
    rd_row = 0;
    frame_w_reg = 11'(mf3_pkg::WIDTH_RST);
    frame_h_reg = 13'(mf3_pkg::HEIGHT_RST);
  endfunction

  // advance the filter by one accepted item and queue the pixel it yields
  function automatic void filter_step(input mf3_pkg::pix_t pix, input logic flush);
    int unsigned   w;
    int unsigned   h;
    mf3_pkg::pix_t v;
    mf3_pkg::pix_t top;
    mf3_pkg::pix_t mid;
    bit            emit;
    bit            border;
    filtered_pix_t res;
    w = clamp_dim(frame_w_reg, MAX_W);
    h = clamp_dim(frame_h_reg, MAX_H);
    v = flush ? '0 : pix;
    top = '0;
    mid = '0;
    emit = (wr_row >= 2) || (wr_row == 1 && wr_col >= 1);
    if (wr_col < MAX_W) begin
      top = row_above[wr_col];
      mid = row_current[wr_col];
      row_above[wr_col] = mid;
      row_current[wr_col] = v;
    end
    for (int r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = top;
    nbhd[5] = mid;
    nbhd[8] = v;
    if (wr_col >= w - 1) begin
      wr_col = 0;
      wr_row = (wr_row + 1) & 13'h1FFF;
    end else begin
      wr_col++;
    end
    if (emit) begin
      border = rd_row == 0 || rd_row >= h - 1 || rd_col == 0 || rd_col >= w - 1;
      res.pix = border ? nbhd[4] : rank_middle();
      res.last = 1'b0;
      if (rd_col >= w - 1) begin
        rd_col = 0;
        if (rd_row >= h - 1) begin
          // frame done: all counters restart, buffers keep their contents
          res.last = 1'b1;
          rd_row = 0;
          wr_row = 0;
          wr_col = 0;
        end else begin
          rd_row++;
        end
      end else begin
        rd_col++;
      end
      expected_pixels.push_back(res);
    end
  endfunction

  function automatic mf3_pkg::pix_t pick_pixel(input pattern_e pat, input int unsigned base);
    int unsigned v;
    case (pat)
      PAT_NOISE:  v = $urandom_range(255);
      PAT_NARROW: v = base + $urandom_range(6);
      PAT_BINARY: v = $urandom_range(1) ? 255 : 0;
      default:    v = ($urandom_range(99) < 15) ? $urandom_range(255) : base;
    endcase
    return mf3_pkg::pix_t'(v);
  endfunction

  // output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        report_error($sformatf("unexpected pixel %0d last %0b", out_tdata, out_tlast));
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.pix || out_tlast !== want.last) begin
          report_error($sformatf("pixel %0d: expected %0d last %0b, got %0d last %0b",
                                 pixels_checked, want.pix, want.last, out_tdata, out_tlast));
        end
        pixels_checked++;
        if (want.last) frames_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d pixels outstanding",
                 quiet_cycles, expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_pixel(input mf3_pkg::pix_t pix, input logic flush);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_step(pix, flush);
    items_sent++;
  endtask

  // one frame plus its trailer; a broken frame is cut short or runs over
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input pattern_e pat, input bit broken);
    int unsigned total;
    int unsigned base;
    total = w * h + w + 1;
    if (broken) total = $urandom_range(total + w, 1);
    base = $urandom_range(249);
    for (int unsigned n = 0; n < total; n++) begin
      if (n < w * h) send_pixel(pick_pixel(pat, base), 1'b0);
      else send_pixel(mf3_pkg::pix_t'($urandom_range(255)), $urandom_range(99) < 80);
    end
  endtask

  // complete any open frame, then let the pipeline empty
  task automatic drain();
    while (wr_col != 0 || wr_row != 0) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), 1'b1);
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w_raw, input int unsigned h_raw);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= mf3_pkg::REG_IMAGE_WIDTH;
    cfg_wdata <= mf3_pkg::CFG_DATA_W'(w_raw & 11'h7FF);
    @(posedge clk);
    frame_w_reg = 11'(w_raw);
    cfg_addr  <= mf3_pkg::REG_IMAGE_HEIGHT;
    cfg_wdata <= mf3_pkg::CFG_DATA_W'(h_raw & 13'h1FFF);
    @(posedge clk);
    frame_h_reg = 13'(h_raw);
    cfg_we <= 1'b0;
  endtask

  task automatic test_corner_frames();
    mf3_pkg::pix_t frame [0:8];
    frame = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128};
    configure(3, 3);
    foreach (frame[i]) send_pixel(frame[i], 1'b0);
    // trailer: flush items carry junk pixels, one plain item mixed in
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hAA, 1'b1);
    send_pixel(8'h55, 1'b0);
    send_pixel(8'hFF, 1'b1);
    // undersized register values clamp to the minimum frame
    configure(2, 0);
    for (int i = 0; i < 9; i++) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), 1'b0);
    for (int i = 0; i < 4; i++) send_pixel(mf3_pkg::pix_t'($urandom_range(255)), 1'b0);
  endtask

  task automatic test_wide_frame();
    configure(100, 4);
    send_frame(100, 4, PAT_NOISE, 1'b0);
  endtask

  task automatic test_tall_frame();
    configure(3, 60);
    send_frame(3, 60, PAT_SPECKLE, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned w;
    int unsigned h;
    int unsigned w_raw;
    int unsigned h_raw;
    start = items_sent;
    w = 6;
    h = 5;
    in_gap_pct = 0;
    out_stall_pct <= 0;
    configure(w, h);
    while (items_sent - start < RANDOM_ITEMS) begin
      // first stretch runs without idling on either side
      if (items_sent - start > CALM_ITEMS) begin
        in_gap_pct = 16;
        out_stall_pct <= 16;
      end
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(19))
          0:       w_raw = $urandom_range(64, 33);
          1, 2, 3: w_raw = $urandom_range(32, 17);
          default: w_raw = $urandom_range(16, 3);
        endcase
        h_raw = ($urandom_range(9) == 0) ? $urandom_range(16, 11) : $urandom_range(10, 3);
        w = w_raw;
        h = h_raw;
        if ($urandom_range(9) == 0) w_raw = $urandom_range(2);
        if ($urandom_range(9) == 0) h_raw = $urandom_range(2);
        w = clamp_dim(w_raw, MAX_W);
        h = clamp_dim(h_raw, MAX_H);
        configure(w_raw, h_raw);
      end
      send_frame(w, h, pattern_e'($urandom_range(3)), $urandom_range(99) < 15);
    end
  endtask

  task automatic test_output_holdoff();
    configure(10, 30);
    in_gap_pct = 0;
    out_stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    send_frame(10, 30, PAT_NOISE, 1'b0);
    in_gap_pct = 16;
    out_stall_pct <= 16;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = mf3_pkg::REG_IMAGE_WIDTH;
    cfg_wdata  = '0;
    in_gap_pct = 16;
    out_stall_pct = 16;
    filter_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_frames();
    test_wide_frame();
    test_tall_frame();
    test_random_frames();
    test_output_holdoff();

    drain();
    repeat (16) @(posedge clk);
    $display("Ran %0d input transfers and checked %0d filtered pixels over %0d frames,",
             items_sent, pixels_checked, frames_seen);
    $display("minimum, wide, tall and random frames, clamped sizes and output hold-off.");
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
